// ===== hdl/lc3b_enc_pkg.sv =====
`default_nettype none

package lc3b_enc_pkg;

   // opcode numbers as carried in the func field
   localparam logic [4:0] FN_BR   = 5'd0;
   localparam logic [4:0] FN_ADD  = 5'd1;
   localparam logic [4:0] FN_LDB  = 5'd2;
   localparam logic [4:0] FN_STB  = 5'd3;
   localparam logic [4:0] FN_JSR  = 5'd4;
   localparam logic [4:0] FN_AND  = 5'd5;
   localparam logic [4:0] FN_LDW  = 5'd6;
   localparam logic [4:0] FN_STW  = 5'd7;
   localparam logic [4:0] FN_RTI  = 5'd8;
   localparam logic [4:0] FN_XOR  = 5'd9;
   localparam logic [4:0] FN_JMP  = 5'd12;
   localparam logic [4:0] FN_SHF  = 5'd13;
   localparam logic [4:0] FN_LEA  = 5'd14;
   localparam logic [4:0] FN_TRAP = 5'd15;
   localparam logic [4:0] FN_FILL = 5'd16;

   // steering values
   localparam logic [2:0] STEER_JSR  = 3'd1;
   localparam logic [2:0] STEER_HALT = 3'd1;

   // operand ranges
   localparam logic signed [16:0] IMM5_MAX   = 17'sd15;
   localparam logic signed [16:0] IMM5_MIN   = -17'sd16;
   localparam logic signed [16:0] OFF6_MAX   = 17'sd31;
   localparam logic signed [16:0] OFF6_MIN   = -17'sd32;
   localparam logic signed [16:0] AMT4_MAX   = 17'sd15;
   localparam logic signed [16:0] TRAP_MAX   = 17'sd255;
   localparam logic signed [16:0] FILL_MIN   = -17'sd32768;
   localparam logic signed [16:0] ZERO_VALUE = 17'sd0;

   // fixed word fragments
   localparam logic [15:0] IMM_FLAG    = 16'h0020;
   localparam logic [15:0] NOT_LOW     = 16'd63;
   localparam logic [15:0] HALT_VECTOR = 16'd37;
   localparam logic [15:0] RET_BASE    = 16'h01C0;
   localparam logic [15:0] JSR_FLAG    = 16'h0800;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_OPCODE = 3'd1,
      ST_BAD_ARG    = 3'd2,
      ST_RANGE      = 3'd3,
      ST_NO_LABEL   = 3'd4,
      ST_NOT_HEX    = 3'd5
   } status_type;

   // pc-relative offset and its range flags
   typedef struct packed {
      logic        fits9;
      logic        fits11;
      logic [8:0]  off9;
      logic [10:0] off11;
   } pcrel_type;

   // one line as held in the input register
   typedef struct packed {
      logic [4:0]         func;
      logic [2:0]         steer;
      logic [2:0]         arg_count;
      logic [2:0]         first_reg;
      logic [2:0]         second_reg;
      logic [2:0]         third_reg;
      logic [2:0]         reg_valid_mask;
      logic signed [16:0] number;
      logic               number_is_hex;
      logic               label_found;
      logic [15:0]        label_address;
   } line_type;

   typedef struct packed {
      logic [15:0] word;
      status_type  status;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/lc3b_enc_pcrel.sv =====
`default_nettype none

module lc3b_enc_pcrel import lc3b_enc_pkg::*; (
   input  wire logic [15:0] target,
   input  wire logic [15:0] location,
   output pcrel_type        pcrel
);

   logic signed [17:0] diff;
   logic signed [17:0] diff_adj;
   logic [16:0]        quot;

   // distance from location + 2, without 16-bit wrap
   assign diff = $signed({2'b00, target}) - $signed({2'b00, location}) - 18'sd2;

   // halve, truncating toward zero
   assign diff_adj = diff + $signed({17'd0, diff[17] & diff[0]});
   assign quot     = diff_adj[17:1];

   // in range when the upper bits are all copies of the sign
   assign pcrel.fits9  = (quot[16:8] == '0) || (quot[16:8] == '1);
   assign pcrel.fits11 = (quot[16:10] == '0) || (quot[16:10] == '1);
   assign pcrel.off9   = quot[8:0];
   assign pcrel.off11  = quot[10:0];

endmodule

`default_nettype wire

// ===== hdl/lc3b_enc_core.sv =====
`default_nettype none

module lc3b_enc_core import lc3b_enc_pkg::*; (
   input  wire line_type    line,
   input  wire pcrel_type   pcrel,
   output result_type       result
);

   logic        ok1;
   logic        ok2;
   logic        ok3;
   logic        num3;
   logic [15:0] word;
   status_type  st;

   // operand usability
   assign ok1  = (line.arg_count > 3'd0) && line.reg_valid_mask[0];
   assign ok2  = (line.arg_count > 3'd1) && line.reg_valid_mask[1];
   assign ok3  = (line.arg_count > 3'd2) && line.reg_valid_mask[2];
   assign num3 = (line.arg_count > 3'd2) && !line.reg_valid_mask[2];

   // encode and check one line
   always_comb begin
      word = (line.func[4] == 1'b0) ? {line.func[3:0], 12'd0} : 16'd0;
      st   = ST_OK;
      case (line.func)
         FN_BR: begin
            if (line.arg_count >= 3'd2) begin
               st = ST_BAD_ARG;
            end else if (line.steer == 3'd0) begin
               if (line.arg_count >= 3'd1) st = ST_BAD_ARG;
            end else if (line.arg_count < 3'd1 || !line.label_found) begin
               st = ST_NO_LABEL;
            end else if (!pcrel.fits9) begin
               st = ST_RANGE;
            end else begin
               word = word | {4'd0, line.steer, pcrel.off9};
            end
         end
         FN_ADD, FN_AND, FN_XOR: begin
            if (line.arg_count >= 3'd4 || !ok1 || !ok2) begin
               st = ST_BAD_ARG;
            end else begin
               word = word | {4'd0, line.first_reg, line.second_reg, 6'd0};
               if (line.func == FN_XOR && line.steer != 3'd0) begin
                  if (line.arg_count >= 3'd3) st = ST_BAD_ARG;
                  else word = word | NOT_LOW;
               end else if (ok3) begin
                  word = word | {13'd0, line.third_reg};
               end else if (!num3) begin
                  st = ST_BAD_ARG;
               end else if (line.number > IMM5_MAX || line.number < IMM5_MIN) begin
                  st = ST_RANGE;
               end else begin
                  word = word | IMM_FLAG | {11'd0, line.number[4:0]};
               end
            end
         end
         FN_LDB, FN_STB, FN_LDW, FN_STW: begin
            if (line.arg_count >= 3'd4 || !ok1 || !ok2 || !num3) begin
               st = ST_BAD_ARG;
            end else if (line.number > OFF6_MAX || line.number < OFF6_MIN) begin
               st = ST_RANGE;
            end else begin
               word = word | {4'd0, line.first_reg, line.second_reg, line.number[5:0]};
            end
         end
         FN_JSR: begin
            if (line.arg_count >= 3'd2) begin
               st = ST_BAD_ARG;
            end else if (line.steer == STEER_JSR) begin
               if (line.arg_count < 3'd1 || !line.label_found) st = ST_NO_LABEL;
               else if (!pcrel.fits11) st = ST_RANGE;
               else word = word | JSR_FLAG | {5'd0, pcrel.off11};
            end else begin
               if (!ok1) st = ST_BAD_ARG;
               else word = word | {7'd0, line.first_reg, 6'd0};
            end
         end
         FN_RTI: begin
            // operands ignored
            word = word;
         end
         FN_JMP: begin
            if (line.arg_count >= 3'd2) begin
               st = ST_BAD_ARG;
            end else if (line.steer == 3'd0) begin
               if (!ok1) st = ST_BAD_ARG;
               else word = word | {7'd0, line.first_reg, 6'd0};
            end else begin
               if (line.arg_count >= 3'd1) st = ST_BAD_ARG;
               else word = word | RET_BASE;
            end
         end
         FN_SHF: begin
            if (line.arg_count >= 3'd4 || !ok1 || !ok2 || !num3) begin
               st = ST_BAD_ARG;
            end else if (line.number > AMT4_MAX || line.number < ZERO_VALUE) begin
               st = ST_RANGE;
            end else begin
               word = word | {4'd0, line.first_reg, line.second_reg,
                              line.steer[1:0], line.number[3:0]};
            end
         end
         FN_LEA: begin
            if (line.arg_count < 3'd2 || !line.label_found) begin
               st = ST_NO_LABEL;
            end else if (!ok1 || line.arg_count >= 3'd3) begin
               st = ST_BAD_ARG;
            end else if (!pcrel.fits9) begin
               st = ST_RANGE;
            end else begin
               word = word | {4'd0, line.first_reg, pcrel.off9};
            end
         end
         FN_TRAP: begin
            if (line.arg_count >= 3'd2) begin
               st = ST_BAD_ARG;
            end else if (line.steer == STEER_HALT) begin
               if (line.arg_count >= 3'd1) st = ST_BAD_ARG;
               else word = word | HALT_VECTOR;
            end else if (line.arg_count < 3'd1 || line.reg_valid_mask[0]
                         || !line.number_is_hex) begin
               st = ST_NOT_HEX;
            end else if (line.number > TRAP_MAX || line.number < ZERO_VALUE) begin
               st = ST_RANGE;
            end else begin
               word = word | {8'd0, line.number[7:0]};
            end
         end
         FN_FILL: begin
            // upper bound is the widest value the field can hold
            if (line.arg_count != 3'd1 || line.reg_valid_mask[0]) begin
               st = ST_BAD_ARG;
            end else if (line.number < FILL_MIN) begin
               st = ST_RANGE;
            end else begin
               word = line.number[15:0];
            end
         end
         default: begin
            st = ST_BAD_OPCODE;
         end
      endcase
      if (st != ST_OK) word = 16'd0;
   end

   assign result.word   = word;
   assign result.status = st;

endmodule

`default_nettype wire

// ===== hdl/lc3b_instruction_encoder.sv =====
// LC-3b line encoder: one transaction in, one encoded word and status out.
// An accepted transaction passes the input register, then the encode logic and the result
// register, and rsp_valid rises once it is held in the result register.
// Throughput: one transaction per cycle while rsp_ready is high; a stalled result register
// also holds the input register. The location counter updates alongside. Reset (synchronous,
// active high) empties both registers and clears the location counter; a csr write loads it.
`default_nettype none

module lc3b_instruction_encoder import lc3b_enc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [4:0]         req_func,
   input  wire logic [2:0]         req_steer,
   input  wire logic [2:0]         req_arg_count,
   input  wire logic [2:0]         req_first_reg,
   input  wire logic [2:0]         req_second_reg,
   input  wire logic [2:0]         req_third_reg,
   input  wire logic [2:0]         req_reg_valid_mask,
   input  wire logic signed [16:0] req_number,
   input  wire logic               req_number_is_hex,
   input  wire logic               req_label_found,
   input  wire logic [15:0]        req_label_address,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_word,
   output logic [2:0]              rsp_status,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data
);

   logic        in_valid_ff;
   logic        in_valid_in;
   line_type    line_ff;
   line_type    line_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  result_ff;
   result_type  result_in;
   logic [15:0] lc_ff;
   logic [15:0] lc_in;
   logic        advance;
   logic        take;
   pcrel_type   pcrel;

   // handshake: the input stage moves on when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   // input register
   assign in_valid_in = take || (in_valid_ff && !advance);
   always_comb begin
      line_in = line_ff;
      if (take) begin
         line_in.func           = req_func;
         line_in.steer          = req_steer;
         line_in.arg_count      = req_arg_count;
         line_in.first_reg      = req_first_reg;
         line_in.second_reg     = req_second_reg;
         line_in.third_reg      = req_third_reg;
         line_in.reg_valid_mask = req_reg_valid_mask;
         line_in.number         = req_number;
         line_in.number_is_hex  = req_number_is_hex;
         line_in.label_found    = req_label_found;
         line_in.label_address  = req_label_address;
      end
   end

   // encode stage
   lc3b_enc_pcrel u_pcrel (
      .target   (line_ff.label_address),
      .location (lc_ff),
      .pcrel    (pcrel)
   );

   lc3b_enc_core u_core (
      .line   (line_ff),
      .pcrel  (pcrel),
      .result (result_in)
   );

   // result register
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // location counter: load on csr write, step by two on a good word
   always_comb begin
      lc_in = lc_ff;
      if (csr_wr_en) begin
         lc_in = csr_wr_data;
      end else if (advance && result_in.status == ST_OK) begin
         lc_in = lc_ff + 16'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         lc_ff        <= 16'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         lc_ff        <= lc_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_word   = result_ff.word;
   assign rsp_status = result_ff.status;

   // an error transaction carries a zero word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_word == 16'd0))
      else $error("error status with nonzero word");

   // a good word steps the location counter by two
   assert property (@(posedge clock) disable iff (reset)
      (advance && result_in.status == ST_OK && !csr_wr_en)
         |=> (lc_ff == $past(lc_ff) + 16'd2))
      else $error("location counter did not advance");

   // an error leaves the location counter alone
   assert property (@(posedge clock) disable iff (reset)
      (advance && result_in.status != ST_OK && !csr_wr_en) |=> $stable(lc_ff))
      else $error("location counter moved on error");

   // a waiting input transaction is never dropped while the result stalls
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("input transaction lost under stall");

endmodule

`default_nettype wire
